// File: hw/rtl/bet_pkg.sv
// ----------------------------------------------------------------------------
// Edge thinning package
// Shared types, constants and the per-pixel window rules of the four passes.
// ----------------------------------------------------------------------------
`default_nettype none

package bet_pkg;

  localparam int unsigned DefMaxWidth  = 512;
  localparam int unsigned DefMaxHeight = 512;
  localparam int unsigned DefMargin    = 5;

  // The window spans offsets -WinRad..WinRad in both directions.
  localparam int unsigned WinRad   = 3;
  localparam int unsigned WinSide  = 2 * WinRad + 1;
  localparam int unsigned WinCells = WinSide * WinSide;
  localparam int unsigned WinIdxW  = $clog2(WinCells);
  localparam int unsigned WinCntW  = $clog2(WinSide);

  localparam int unsigned CfgDataW = 10;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [1:0] PASS_CORNER  = 2'd0;
  localparam logic [1:0] PASS_CROWD   = 2'd1;
  localparam logic [1:0] PASS_STRAIGHT = 2'd2;
  localparam logic [1:0] PASS_DIAG    = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [8:0] pos_x;
    logic [8:0] pos_y;
    logic       pixel_in;
  } bet_in_t;

  typedef struct packed {
    logic       pixel_out;
    logic [1:0] cmd_echo;
  } bet_out_t;

  typedef logic [WinCells-1:0] win_t;

  function automatic int unsigned wi(int dx, int dy);
    return int'(unsigned'((dy + WinRad) * WinSide + (dx + WinRad)));
  endfunction

  function automatic win_t pass_corner(win_t w);
    win_t n;
    logic up, lf, rt, dn;
    n  = w;
    up = w[wi(0, -1)];
    lf = w[wi(-1, 0)];
    rt = w[wi(1, 0)];
    dn = w[wi(0, 1)];
    if (w[wi(0, 0)] && ((rt && dn) || (rt && up) || (lf && dn) || (lf && up))) begin
      n[wi(0, 0)] = 1'b0;
    end
    return n;
  endfunction

  function automatic win_t pass_crowd(win_t w);
    win_t n;
    logic [3:0] cnt;
    n   = w;
    cnt = '0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        cnt = cnt + 4'(w[wi(dx, dy)]);
      end
    end
    if (cnt > 4'd3) begin
      n[wi(0, 0)] = 1'b0;
    end
    return n;
  endfunction

  function automatic win_t pass_straight(win_t w);
    win_t n;
    logic ur, dl, r1, d1, dr, r2, d2, r3, r2u, r2d, d3, d2l, d2r;
    n   = w;
    ur  = w[wi(1, -1)];
    dl  = w[wi(-1, 1)];
    r1  = w[wi(1, 0)];
    d1  = w[wi(0, 1)];
    dr  = w[wi(1, 1)];
    r2  = w[wi(2, 0)];
    d2  = w[wi(0, 2)];
    r3  = w[wi(3, 0)];
    r2u = w[wi(2, -1)];
    r2d = w[wi(2, 1)];
    d3  = w[wi(0, 3)];
    d2l = w[wi(-1, 2)];
    d2r = w[wi(1, 2)];
    if (w[wi(0, 0)]) begin
      if (d2 && !d1 && (dr || dl)) begin
        n[wi(-1, 1)] = 1'b0;
        n[wi(1, 1)]  = 1'b0;
        n[wi(0, 1)]  = 1'b1;
      end
      if (d3 && !d1 && !d2 && (dr || dl) && (d2r || d2l)) begin
        n[wi(1, 1)]  = 1'b0;
        n[wi(-1, 1)] = 1'b0;
        n[wi(1, 2)]  = 1'b0;
        n[wi(-1, 2)] = 1'b0;
        n[wi(0, 1)]  = 1'b1;
        n[wi(0, 2)]  = 1'b1;
      end
      if (r2 && !r1 && (dr || ur)) begin
        n[wi(1, 1)]  = 1'b0;
        n[wi(1, -1)] = 1'b0;
        n[wi(1, 0)]  = 1'b1;
      end
      if (r3 && !r1 && !r2 && (dr || ur) && (r2d || r2u)) begin
        n[wi(1, 1)]  = 1'b0;
        n[wi(1, -1)] = 1'b0;
        n[wi(2, 1)]  = 1'b0;
        n[wi(2, -1)] = 1'b0;
        n[wi(1, 0)]  = 1'b1;
        n[wi(2, 0)]  = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic win_t pass_diag(win_t w);
    win_t n;
    logic kill;
    n = w;
    kill = 1'b0;
    kill |= w[wi(0,1)] && w[wi(1,-1)] && w[wi(2,-1)];
    kill |= w[wi(0,1)] && w[wi(-1,-1)] && w[wi(-2,-1)];
    kill |= w[wi(0,-1)] && w[wi(1,1)] && w[wi(2,1)];
    kill |= w[wi(0,-1)] && w[wi(-1,1)] && w[wi(-2,1)];
    kill |= w[wi(-1,-1)] && w[wi(-1,-2)] && w[wi(-1,-3)] && w[wi(1,1)] && w[wi(2,1)]
            && w[wi(3,1)];
    kill |= w[wi(1,-1)] && w[wi(1,-2)] && w[wi(1,-3)] && w[wi(-1,1)] && w[wi(-2,1)]
            && w[wi(-3,1)];
    kill |= w[wi(-1,1)] && w[wi(-1,2)] && w[wi(-1,3)] && w[wi(1,-1)] && w[wi(2,-1)]
            && w[wi(3,-1)];
    kill |= w[wi(1,1)] && w[wi(1,2)] && w[wi(1,3)] && w[wi(-1,-1)] && w[wi(-2,-1)]
            && w[wi(-3,-1)];
    kill |= w[wi(-1,-1)] && w[wi(-2,-2)] && w[wi(1,-1)] && w[wi(2,-2)];
    kill |= w[wi(-1,-1)] && w[wi(-2,-2)] && w[wi(-1,1)] && w[wi(-2,2)];
    kill |= w[wi(1,1)] && w[wi(2,2)] && w[wi(1,-1)] && w[wi(2,-2)];
    kill |= w[wi(1,1)] && w[wi(2,2)] && w[wi(-1,1)] && w[wi(-2,2)];
    kill |= w[wi(-1,0)] && w[wi(-2,-1)] && w[wi(-3,-2)] && w[wi(1,-1)] && w[wi(2,-2)];
    kill |= w[wi(-1,0)] && w[wi(-2,1)] && w[wi(-3,2)] && w[wi(1,1)] && w[wi(2,2)];
    kill |= w[wi(0,1)] && w[wi(1,2)] && w[wi(2,3)] && w[wi(1,-1)] && w[wi(2,-2)];
    kill |= w[wi(0,1)] && w[wi(-1,2)] && w[wi(-2,3)] && w[wi(-1,-1)] && w[wi(-2,-2)];
    if (w[wi(0, 0)] && kill) begin
      n[wi(0, 0)] = 1'b0;
    end
    return n;
  endfunction

  function automatic win_t thin_step(logic [1:0] pass, win_t w);
    win_t n;
    case (pass)
      PASS_CORNER:   n = pass_corner(w);
      PASS_CROWD:    n = pass_crowd(w);
      PASS_STRAIGHT: n = pass_straight(w);
      PASS_DIAG:     n = pass_diag(w);
      default:       n = w;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/binary_edge_thinning_filter.sv
// ----------------------------------------------------------------------------
// Binary edge thinning filter
// Frame store of one-bit pixels with write, read and an in-place thinning run.
// ----------------------------------------------------------------------------
// A write is answered in the cycle after acceptance; a read passes through
// ST_RDPIX first. Writes stream at one per cycle while the output is not
// stalled; a new read is not taken until the last is answered. A run makes
// four passes; in each, every interior pixel reads a 7x7 window through the
// single frame memory read port and writes it back through the write port.
// Reset clears control state only; frame memory holds garbage until written.
`default_nettype none

module binary_edge_thinning_filter
  import bet_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  parameter int unsigned MARGIN     = DefMargin
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bet_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bet_out_t                 out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned DimW  = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int unsigned CW    = (DimW > CfgDataW) ? DimW : CfgDataW;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RDPIX = 6'b000010,
    ST_RD    = 6'b000100,
    ST_CAP   = 6'b001000,
    ST_EVAL  = 6'b010000,
    ST_WR    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [DimW-1:0] width_q, width_d, height_q, height_d;
  logic [DimW-1:0] x_q, x_d, y_q, y_d;
  logic [1:0] pass_q, pass_d;
  logic [WinIdxW-1:0] k_q, k_d, rd_k_q;
  logic [WinCntW-1:0] wx_q, wx_d, wy_q, wy_d;
  logic rd_vld_q, rd_vld_d;
  win_t win_q;
  logic out_valid_q, out_valid_d;
  bet_out_t out_q, out_d;

  logic frame_mem [Depth];
  logic mem_rdata_q;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, win_addr, pos_addr;
  logic mem_wdata;

  logic in_acc, in_store, last_cell, has_interior;
  logic [CW-1:0] cfg_val;
  logic [DimW-1:0] cfg_clip;
  logic [DimW-1:0] win_x, win_y;

  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assign in_store = (32'(in_data_i.pos_x) < MAX_WIDTH) && (32'(in_data_i.pos_y) < MAX_HEIGHT);
  assign pos_addr = AW'(32'(in_data_i.pos_y) * MAX_WIDTH + 32'(in_data_i.pos_x));
  assign win_x = x_q + DimW'(wx_q) - DimW'(WinRad);
  assign win_y = y_q + DimW'(wy_q) - DimW'(WinRad);
  assign win_addr = AW'(32'(win_y) * MAX_WIDTH + 32'(win_x));
  assign last_cell = (32'(k_q) == WinCells - 1);
  assign has_interior = (32'(width_q) > 2 * MARGIN) && (32'(height_q) > 2 * MARGIN);

  assign cfg_val = CW'(cfg_data_i);
  always_comb begin
    if (cfg_val == '0) begin
      cfg_clip = DimW'(1);
    end else if (32'(cfg_val) > ((cfg_index_i == CFG_WIDTH) ? MAX_WIDTH : MAX_HEIGHT)) begin
      cfg_clip = (cfg_index_i == CFG_WIDTH) ? DimW'(MAX_WIDTH) : DimW'(MAX_HEIGHT);
    end else begin
      cfg_clip = DimW'(cfg_val);
    end
  end

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    x_d         = x_q;
    y_d         = y_q;
    pass_d      = pass_q;
    k_d         = k_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    rd_vld_d    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = win_addr;
    mem_wdata   = win_q[k_q];
    mem_raddr   = win_addr;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WIDTH) begin
        width_d = cfg_clip;
      end else begin
        height_d = cfg_clip;
      end
    end

    case (state_q)
      ST_IDLE: begin
        mem_raddr = pos_addr;
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_WRITE: begin
              mem_we      = in_store;
              mem_waddr   = pos_addr;
              mem_wdata   = in_data_i.pixel_in;
              out_valid_d = 1'b1;
              out_d       = '{pixel_out: 1'b0, cmd_echo: CMD_WRITE};
            end
            CMD_READ: begin
              state_d = ST_RDPIX;
              out_d   = '{pixel_out: 1'b0, cmd_echo: CMD_READ};
              if (!in_store) begin
                out_d.cmd_echo = 2'(in_data_i.cmd);
              end
            end
            CMD_RUN: begin
              if (has_interior) begin
                state_d = ST_RD;
                x_d     = DimW'(MARGIN);
                y_d     = DimW'(MARGIN);
                pass_d  = PASS_CORNER;
                k_d     = '0;
                wx_d    = '0;
                wy_d    = '0;
              end else begin
                out_valid_d = 1'b1;
                out_d       = '{pixel_out: 1'b0, cmd_echo: CMD_RUN};
              end
            end
            default: begin
              out_valid_d = 1'b1;
              out_d       = '{pixel_out: 1'b0, cmd_echo: in_data_i.cmd};
            end
          endcase
          if (in_data_i.cmd == CMD_READ) begin
            out_d.pixel_out = in_store;
          end
        end
      end
      ST_RDPIX: begin
        state_d         = ST_IDLE;
        out_valid_d     = 1'b1;
        out_d.pixel_out = out_q.pixel_out && mem_rdata_q;
      end
      ST_RD: begin
        rd_vld_d = 1'b1;
        k_d      = k_q + 1'b1;
        if (32'(wx_q) == WinSide - 1) begin
          wx_d = '0;
          wy_d = wy_q + 1'b1;
        end else begin
          wx_d = wx_q + 1'b1;
        end
        if (last_cell) begin
          state_d = ST_CAP;
          k_d     = '0;
          wx_d    = '0;
          wy_d    = '0;
        end
      end
      ST_CAP: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        mem_we = 1'b1;
        k_d    = k_q + 1'b1;
        if (32'(wx_q) == WinSide - 1) begin
          wx_d = '0;
          wy_d = wy_q + 1'b1;
        end else begin
          wx_d = wx_q + 1'b1;
        end
        if (last_cell) begin
          state_d = ST_RD;
          k_d     = '0;
          wx_d    = '0;
          wy_d    = '0;
          if (32'(x_q) + 1 + MARGIN >= 32'(width_q)) begin
            x_d = DimW'(MARGIN);
            if (32'(y_q) + 1 + MARGIN >= 32'(height_q)) begin
              y_d = DimW'(MARGIN);
              pass_d = pass_q + 1'b1;
              if (pass_q == PASS_DIAG) begin
                state_d     = ST_IDLE;
                out_valid_d = 1'b1;
                out_d       = '{pixel_out: 1'b0, cmd_echo: CMD_RUN};
              end
            end else begin
              y_d = y_q + 1'b1;
            end
          end else begin
            x_d = x_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= frame_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    rd_k_q <= k_q;
    out_q  <= out_d;
    if (state_q == ST_EVAL) begin
      win_q <= thin_step(pass_q, win_q);
    end else if (rd_vld_q) begin
      win_q[rd_k_q] <= mem_rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= DimW'(320);
      height_q    <= DimW'(240);
      x_q         <= '0;
      y_q         <= '0;
      pass_q      <= PASS_CORNER;
      k_q         <= '0;
      wx_q        <= '0;
      wy_q        <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      x_q         <= x_d;
      y_q         <= y_d;
      pass_q      <= pass_d;
      k_q         <= k_d;
      wx_q        <= wx_d;
      wy_q        <= wy_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bet_checker.sv
// ----------------------------------------------------------------------------
// Edge thinning port checker
// Watches the top-level ports and flags handshake and result ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

module bet_checker
  import bet_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire bet_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire bet_out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result transaction changed while stalled.");

  a_write_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.cmd == CMD_WRITE |=> out_valid_o && out_data_o.cmd_echo == CMD_WRITE)
    else $error("Write transaction was not answered in the next cycle.");

  a_busy_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == CMD_RUN || in_data_i.cmd == CMD_READ)
      |=> !in_ready_o || out_valid_o)
    else $error("New transaction accepted while a read or run was pending.");

  a_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cmd_echo != CMD_READ |-> !out_data_o.pixel_out)
    else $error("Nonzero pixel returned for a command other than read.");

endmodule

bind binary_edge_thinning_filter bet_checker u_bet_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
